/* design/gpwm_pkg.sv */
// shared types, constants and the carryless partial product function
package gpwm_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned PP_W       = WORD_W + HALF_W - 1;
  localparam int unsigned PROD_W     = 2 * WORD_W - 1;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 1;

  // register index, taken from paddr[3] (registers are 8 bytes apart)
  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 1'b0;

  typedef struct packed {
    logic [WORD_W-1:0] b_word;
    logic [WORD_W-1:0] addend_word;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] product_word;
    logic [WORD_W-1:0] carry_word;
    logic              last_out;
  } out_item_t;

  // head of the item queue as seen by the back end
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

  // 64 x 32 carryless product, each output bit an xor over its own diagonal
  function automatic logic [PP_W-1:0] clmul_64x32(input logic [WORD_W-1:0] x,
                                                  input logic [HALF_W-1:0] y);
    logic [PP_W-1:0]   r;
    logic [HALF_W-1:0] t;
    for (int k = 0; k < PP_W; k++) begin
      t = '0;
      for (int j = 0; j < HALF_W; j++) begin
        if ((k - j) >= 0 && (k - j) < WORD_W) begin
          t[j] = y[j] & x[k-j];
        end
      end
      r[k] = ^t;
    end
    return r;
  endfunction

endpackage

/* design/gpwm_cfg.sv */
// apb-style configuration register holding the multiplier word
module gpwm_cfg
  import gpwm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [WORD_W-1:0]     multiplier_o
);

  logic [WORD_W-1:0]    mult_q;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= '0;
    end else if (wr_en && reg_idx == REG_MULTIPLIER) begin
      mult_q <= pwdata;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MULTIPLIER: prdata = mult_q;
      default:        prdata = '0;
    endcase
  end

  assign multiplier_o = mult_q;

endmodule

/* design/gpwm_front.sv */
// front end: accepts input words and queues them for the back end
module gpwm_front
  import gpwm_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  output q_head_t  head_o,
  input  logic     head_ready_i
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  in_item_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;
  in_item_t         wr_item;

  assign full  = (cnt_q == CNT_W'(DEPTH));
  assign do_wr = push & ~full;
  assign do_rd = head_o.valid & head_ready_i;

  // tag the word: only the low bit of last carries meaning
  always_comb begin
    wr_item      = in_item_i;
    wr_item.last = in_item_i.last;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

/* design/gpwm_back.sv */
// back end: two-stage carryless multiply with carry chaining and result register
module gpwm_back
  import gpwm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  q_head_t           head_i,
  output logic              head_ready_o,
  input  logic [WORD_W-1:0] multiplier_i,
  output logic              empty,
  input  logic              pop,
  output out_item_t         out_item_o
);

  // stage 1: partial products against each multiplier half
  logic              s1_valid_q;
  logic [PP_W-1:0]   pp_lo_q, pp_hi_q;
  logic [WORD_W-1:0] s1_addend_q;
  logic              s1_last_q;

  // stage 2: result register and kept carry
  logic              out_valid_q;
  out_item_t         out_q;
  logic [WORD_W-1:0] carry_q;

  logic              s1_ready, s2_ready;
  logic [PROD_W-1:0] prod;
  logic [WORD_W-1:0] prod_low, prod_high;

  assign s2_ready     = ~out_valid_q | pop;
  assign s1_ready     = ~s1_valid_q | s2_ready;
  assign head_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= head_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && head_i.valid) begin
      pp_lo_q     <= clmul_64x32(head_i.item.b_word, multiplier_i[HALF_W-1:0]);
      pp_hi_q     <= clmul_64x32(head_i.item.b_word, multiplier_i[WORD_W-1:HALF_W]);
      s1_addend_q <= head_i.item.addend_word;
      s1_last_q   <= head_i.item.last;
    end
  end

  assign prod      = {{(PROD_W - PP_W){1'b0}}, pp_lo_q} ^ {pp_hi_q, {HALF_W{1'b0}}};
  assign prod_low  = prod[WORD_W-1:0];
  assign prod_high = {1'b0, prod[PROD_W-1:WORD_W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      carry_q     <= '0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        carry_q <= s1_last_q ? '0 : prod_high;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      out_q.product_word <= s1_addend_q ^ prod_low ^ carry_q;
      out_q.carry_word   <= prod_high;
      out_q.last_out     <= s1_last_q;
    end
  end

  assign empty      = ~out_valid_q;
  assign out_item_o = out_q;

endmodule

/* design/gf2_poly_word_mul_accumulate.sv */
// top level of the carryless multiword-by-word multiply-accumulate block
//
// input channel: a queue write port. a transfer happens at a rising edge with
//   push high and full low; each item is one 64-bit word of the multiplicand
//   (lowest word first), an addend word and the last flag of the sequence.
// result channel: a queue read port. while empty is low the oldest result sits
//   on out_item_o; a transfer happens at a rising edge with pop high.
// configuration: apb-style port, multiplier word at byte offset 0, 64-bit data,
//   pready tied high; write it only while no items are in flight.
// path: an input word goes through the queue, then the partial products, then
//   is combined into the result register.
// throughput: one word per cycle while pop keeps the result register drained;
//   the two-stage multiply pipeline advances whenever the result register drains.
// the kept carry is cleared after a word marked last and at reset.
// stall: when pop stays low the pipeline holds and the input queue fills
//   (QUEUE_DEPTH words) before full rises; nothing is dropped.
// reset: asynchronous, active low; clears queue, pipeline valids, carry and
//   multiplier.
module gf2_poly_word_mul_accumulate
  import gpwm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input queue side
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item_i,
  // result queue side
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [WORD_W-1:0] multiplier;
  q_head_t           head;
  logic              head_ready;

  // multiplier register
  gpwm_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .multiplier_o (multiplier)
  );

  // front end: input transfers land in a short queue
  gpwm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_item_i    (in_item_i),
    .head_o       (head),
    .head_ready_i (head_ready)
  );

  // back end: multiply, chain the carry, hold the result until popped
  gpwm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_ready_o (head_ready),
    .multiplier_i (multiplier),
    .empty        (empty),
    .pop          (pop),
    .out_item_o   (out_item_o)
  );

`ifndef ASSERT_OFF
  // an accepted word is waiting for the back end on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> head.valid)
    else $error("accepted word missing from queue head");

  // a queued word is not lost while the back end stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head.valid && !head_ready) |=> head.valid)
    else $error("queue head dropped while back end stalled");

  // a write to the multiplier register takes effect
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[CFG_ADDR_W-1] == REG_MULTIPLIER)
      |=> multiplier == $past(pwdata))
    else $error("multiplier write not applied");
`endif

endmodule
